### design/xfbr_pkg.sv
package xfbr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 2;

  // Poll status codes as seen on poll_status
  typedef enum logic [2:0] {
    ST_GOOD  = 3'd0,
    ST_IDLE  = 3'd1,
    ST_RECV  = 3'd2,
    ST_FAULT = 3'd3,
    ST_LIMIT = 3'd4
  } status_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_BYTE   = 2'd0,
    CFG_FRAME_LENGTH = 2'd1,
    CFG_FAULT_LIMIT  = 2'd2
  } cfg_idx_e;

  localparam logic [ByteW-1:0] StartByteRst   = 8'd0;
  localparam logic [ByteW-1:0] FrameLengthRst = 8'd16;
  localparam logic [ByteW-1:0] FaultLimitRst  = 8'd3;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] frame_length;
    logic [ByteW-1:0] fault_limit;
  } cfg_t;

  typedef struct packed {
    logic             store_valid;
    logic [ByteW-1:0] store_index;
    logic [ByteW-1:0] store_byte;
    status_e          poll_status;
    logic             link_error;
  } result_t;

endpackage

### design/xor_framed_byte_receiver.sv
// Start-byte framed receiver with running XOR checksum.
//
// Input channel (in_valid_i / in_stall_o): one transfer per item, func_i = 0
// carries a received byte in rx_byte_i, func_i = 1 polls the frame status.
// Output channel (out_valid_o / out_stall_i): exactly one result transfer per
// input item, in order. A byte accepted into a frame shows store_valid_o with
// its payload position and value; a poll shows poll_status_o; link_error_o
// is the sticky error flag after the item.
// Configuration channel (cfg_valid_i / cfg_ready_o): index 0 start byte,
// 1 frame length, 2 fault limit; always ready; write only while idle.
//
// The frame state and the result register update at the edge that accepts
// the item. Throughput is one item per cycle, set by the single result
// register; in_stall_o rises only while that register is full and the
// receiver stalls, and the held result does not change.
// Reset returns the registers to their defaults (start 0, length 16,
// limit 3), clears the frame state, fault counter and link error, and
// empties the output register.
module xor_framed_byte_receiver
  import xfbr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               store_valid_o,
  output logic [ByteW-1:0]   store_index_o,
  output logic [ByteW-1:0]   store_byte_o,
  output logic [2:0]         poll_status_o,
  output logic               link_error_o
);

  cfg_t    cfg;
  result_t core_res;
  result_t out_res;
  logic    in_accept;
  logic    out_blocked;

  assign cfg_ready_o = 1'b1;

  // accept whenever the result register is free or draining this cycle
  assign in_stall_o = out_blocked;
  assign in_accept  = in_valid_i & ~out_blocked;

  xfbr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  xfbr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .func_i    (func_i),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg),
    .result_o  (core_res)
  );

  xfbr_out_reg u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (in_accept),
    .result_i       (core_res),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .full_stalled_o (out_blocked),
    .result_o       (out_res)
  );

  assign store_valid_o = out_res.store_valid;
  assign store_index_o = out_res.store_index;
  assign store_byte_o  = out_res.store_byte;
  assign poll_status_o = out_res.poll_status;
  assign link_error_o  = out_res.link_error;

endmodule

### design/xfbr_cfg_regs.sv
module xfbr_cfg_regs
  import xfbr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [ByteW-1:0]   wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte   <= StartByteRst;
      cfg_q.frame_length <= FrameLengthRst;
      cfg_q.fault_limit  <= FaultLimitRst;
    end else if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_START_BYTE:   cfg_q.start_byte   <= wr_data_i;
        CFG_FRAME_LENGTH: cfg_q.frame_length <= wr_data_i;
        CFG_FAULT_LIMIT:  cfg_q.fault_limit  <= wr_data_i;
        default:          ; // unmapped index: drop the write
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/xfbr_core.sv
module xfbr_core
  import xfbr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             func_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  cfg_t             cfg_i,
  output result_t          result_o
);

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_RECV  = 2'd1,
    PH_GOOD  = 2'd2,
    PH_FAULT = 2'd3
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] left_q, left_d;
  logic [ByteW-1:0] pos_q, pos_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [ByteW-1:0] fcnt_q, fcnt_d;
  logic             err_q, err_d;

  logic [ByteW-1:0] xor_next;
  logic [ByteW-1:0] left_dec;
  logic [ByteW-1:0] fcnt_inc;

  assign xor_next = xor_q ^ rx_byte_i;
  assign left_dec = left_q - 8'd1;
  assign fcnt_inc = (fcnt_q == 8'hFF) ? fcnt_q : fcnt_q + 8'd1;

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    pos_d    = pos_q;
    xor_d    = xor_q;
    fcnt_d   = fcnt_q;
    err_d    = err_q;
    result_o.store_valid = 1'b0;
    result_o.store_index = '0;
    result_o.store_byte  = '0;
    result_o.poll_status = ST_IDLE;
    if (!func_i) begin
      case (phase_q)
        PH_WAIT: begin
          if (rx_byte_i == cfg_i.start_byte) begin
            // zero length counts as one
            left_d  = (cfg_i.frame_length == '0) ? 8'd1 : cfg_i.frame_length;
            pos_d   = '0;
            xor_d   = rx_byte_i;
            phase_d = PH_RECV;
          end
        end
        PH_RECV: begin
          result_o.store_valid = 1'b1;
          result_o.store_index = pos_q;
          result_o.store_byte  = rx_byte_i;
          xor_d  = xor_next;
          pos_d  = pos_q + 8'd1;
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = (xor_next == '0) ? PH_GOOD : PH_FAULT;
          end
        end
        default: ; // frame done: ignore bytes until polled
      endcase
    end else begin
      case (phase_q)
        PH_WAIT: result_o.poll_status = ST_IDLE;
        PH_RECV: result_o.poll_status = ST_RECV;
        PH_GOOD: begin
          result_o.poll_status = ST_GOOD;
          phase_d = PH_WAIT;
        end
        default: begin
          fcnt_d = fcnt_inc;
          if (fcnt_inc > cfg_i.fault_limit) begin
            err_d = 1'b1;
            result_o.poll_status = ST_LIMIT;
          end else begin
            result_o.poll_status = ST_FAULT;
          end
          phase_d = PH_WAIT;
        end
      endcase
    end
    result_o.link_error = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      left_q  <= '0;
      pos_q   <= '0;
      xor_q   <= '0;
      fcnt_q  <= '0;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
      xor_q   <= xor_d;
      fcnt_q  <= fcnt_d;
      err_q   <= err_d;
    end
  end

endmodule

### design/xfbr_out_reg.sv
module xfbr_out_reg
  import xfbr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output logic    full_stalled_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // Hold while the receiver stalls, refill on every accepted item
  assign valid_d        = load_i | (valid_q & out_stall_i);
  assign full_stalled_o = valid_q & out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

### design/xfbr_checker.sv
module xfbr_checker
  import xfbr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             store_valid_o,
  input logic [ByteW-1:0] store_index_o,
  input logic [ByteW-1:0] store_byte_o,
  input logic [2:0]       poll_status_o,
  input logic             link_error_o
);

  // every accepted item shows a result on the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item produced no result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(store_valid_o)
      && $stable(store_index_o) && $stable(store_byte_o)
      && $stable(poll_status_o) && $stable(link_error_o))
    else $error("stalled result changed");

  // stored bytes come from byte items, which report idle status
  a_store_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_valid_o |-> poll_status_o == ST_IDLE)
    else $error("stored byte with non-idle status");

  // limit exceeded implies the sticky error
  a_limit_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && poll_status_o == ST_LIMIT |-> link_error_o)
    else $error("limit reported without link error");

  // unused store fields are zero
  a_store_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !store_valid_o |-> store_index_o == '0 && store_byte_o == '0)
    else $error("store fields set without store_valid");

endmodule

bind xor_framed_byte_receiver xfbr_checker u_xfbr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .store_valid_o (store_valid_o),
  .store_index_o (store_index_o),
  .store_byte_o  (store_byte_o),
  .poll_status_o (poll_status_o),
  .link_error_o  (link_error_o)
);
